// ===== rtl/cubic_bspline_evaluator_defines.svh =====
// Assertion macros for the spline evaluator checks
`ifndef CUBIC_BSPLINE_EVALUATOR_DEFINES_SVH
`define CUBIC_BSPLINE_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CBSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbse check failed");

// next-cycle implication, disabled in reset
`define CBSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbse check failed");

// holds in the cycle after reset is seen
`define CBSE_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("cbse reset check failed");

`endif

// ===== rtl/cbse_pkg.sv =====
package cbse_pkg;

    localparam int NUM_COEFFS = 256;
    localparam int COEFF_AW   = $clog2(NUM_COEFFS);
    localparam int BANKS      = 4;
    localparam int BANK_SEL_W = $clog2(BANKS);
    localparam int BANK_DEPTH = NUM_COEFFS / BANKS;
    localparam int DIV_STEPS  = 24;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] CFG_NODE_ORIGIN  = 2'd0;
    localparam logic [1:0] CFG_NODE_SPACING = 2'd1;
    localparam logic [1:0] CFG_COEFF_COUNT  = 2'd2;

    typedef logic [31:0] t_coeff;
    typedef t_coeff [BANKS-1:0] t_bank_data;

    // weight order: cube(g), B(g), B(f), cube(f)
    typedef logic [30:0] t_weight;
    typedef t_weight [BANKS-1:0] t_weight_set;

    typedef struct packed {
        logic                op;
        logic [COEFF_AW-1:0] idx;
        t_coeff              cval;
        logic                err;
    } t_tag;

endpackage

// ===== rtl/cbse_div.sv =====
module cbse_div import cbse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_tag                  i_tag,
    input  logic signed [32:0]    i_d,
    input  logic [30:0]           i_spacing,
    output logic                  o_valid,
    output t_tag                  o_tag,
    output logic [DIV_STEPS-1:0]  o_q
);

    logic [DIV_STEPS-1:0] r_valid;
    t_tag                 r_tag  [DIV_STEPS];
    logic [31:0]          r_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_tail [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q    [DIV_STEPS];

    t_tag                 n_tag  [DIV_STEPS];
    logic [31:0]          n_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_tail [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_q    [DIV_STEPS];

    t_tag                 s_tag  [DIV_STEPS];
    logic [31:0]          s_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] s_tail [DIV_STEPS];
    logic [DIV_STEPS-1:0] s_q    [DIV_STEPS];
    logic [31:0]          trial  [DIV_STEPS];

    t_tag in_tag;
    logic bad;

    // quotient must stay below 2^24: d < spacing * 2^8
    assign bad = (i_spacing == 31'd0) || i_d[32] || (i_d == 33'sd0)
              || ({7'b0, i_d[31:0]} >= {i_spacing, 8'h00});

    always_comb begin
        in_tag     = i_tag;
        in_tag.err = (i_tag.op == OP_EVAL) && bad;
    end

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                s_tag[k]  = in_tag;
                s_rem[k]  = {8'h00, i_d[31:8]};
                s_tail[k] = {i_d[7:0], 16'h0000};
                s_q[k]    = '0;
            end else begin
                s_tag[k]  = r_tag[k-1];
                s_rem[k]  = r_rem[k-1];
                s_tail[k] = r_tail[k-1];
                s_q[k]    = r_q[k-1];
            end
            trial[k]  = {s_rem[k][30:0], s_tail[k][DIV_STEPS-1]};
            n_tag[k]  = s_tag[k];
            n_tail[k] = {s_tail[k][DIV_STEPS-2:0], 1'b0};
            if (trial[k] >= {1'b0, i_spacing}) begin
                n_rem[k] = trial[k] - {1'b0, i_spacing};
                n_q[k]   = {s_q[k][DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[k];
                n_q[k]   = {s_q[k][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_tag[k]  <= n_tag[k];
                r_rem[k]  <= n_rem[k];
                r_tail[k] <= n_tail[k];
                r_q[k]    <= n_q[k];
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_tag   = r_tag[DIV_STEPS-1];
    assign o_q     = r_q[DIV_STEPS-1];

endmodule

// ===== rtl/cbse_weights.sv =====
module cbse_weights import cbse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_f,
    output t_weight_set o_weight
);

    localparam logic [50:0] ONE_Q48  = 51'd1 << 48;
    localparam logic [50:0] RND_Q20  = 51'd1 << 19;

    // lane 0 carries g = 1 - f, lane 1 carries f
    logic [16:0] w      [2];
    logic [16:0] r_a_w  [2];
    logic [33:0] r_a_w2 [2];
    logic [48:0] r_b_w3 [2];
    logic [50:0] r_b_prt[2];
    logic [50:0] cube_t [2];
    logic [50:0] bmid_t [2];
    t_weight_set r_weight;

    assign w[0] = 17'h10000 - {1'b0, i_f};
    assign w[1] = {1'b0, i_f};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cube_t[l] = {2'b00, r_b_w3[l]} + RND_Q20;
            bmid_t[l] = r_b_prt[l] - 51'd3 * {2'b00, r_b_w3[l]} + RND_Q20;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_a_w[l]   <= w[l];
                r_a_w2[l]  <= {17'b0, w[l]} * {17'b0, w[l]};
                r_b_w3[l]  <= {15'b0, r_a_w2[l]} * {32'b0, r_a_w[l]};
                r_b_prt[l] <= ONE_Q48 + 51'd3 * {2'b00, r_a_w[l], 32'h0}
                            + 51'd3 * {1'b0, r_a_w2[l], 16'h0};
            end
            r_weight[0] <= {2'b00, cube_t[0][48:20]};
            r_weight[1] <= bmid_t[0][50:20];
            r_weight[2] <= bmid_t[1][50:20];
            r_weight[3] <= {2'b00, cube_t[1][48:20]};
        end
    end

    assign o_weight = r_weight;

endmodule

// ===== rtl/cbse_coeff_mem.sv =====
module cbse_coeff_mem import cbse_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_we,
    input  logic [COEFF_AW-1:0] i_waddr,
    input  t_coeff              i_wdata,
    input  logic [COEFF_AW-1:0] i_base,
    output t_bank_data          o_rdata
);

    // four banks by index mod 4: any four consecutive entries hit each bank once
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        t_coeff                r_mem [BANK_DEPTH];
        t_coeff                r_rdata;
        logic [BANK_SEL_W-1:0] off;
        logic [COEFF_AW-1:0]   ridx;

        assign off  = BANK_SEL_W'(b) - i_base[BANK_SEL_W-1:0];
        assign ridx = i_base + {{(COEFF_AW-BANK_SEL_W){1'b0}}, off};

        always_ff @(posedge i_clk) begin
            if (i_en && i_we && (i_waddr[BANK_SEL_W-1:0] == BANK_SEL_W'(b))) begin
                r_mem[i_waddr[COEFF_AW-1:BANK_SEL_W]] <= i_wdata;
            end
            if (i_en) begin
                r_rdata <= r_mem[ridx[COEFF_AW-1:BANK_SEL_W]];
            end
        end

        assign o_rdata[b] = r_rdata;
    end

endmodule

// ===== rtl/cubic_bspline_evaluator.sv =====
// Uniform cubic B-spline evaluator, signed Q16.16 in, Q23.16 out.
// Config: write i_cfg_we with i_cfg_index 0 node origin, 1 node spacing,
// 2 coefficient count; only while no request is in flight.
// Input channel (i_in_valid / o_in_stall): a request is taken on a clock edge
// with valid high and stall low. A load writes one coefficient; an evaluate
// reads four neighbouring coefficients from a four-bank table and weights them.
// Output channel (o_out_valid / i_out_stall): one result per request, in order.
// Throughput: one request per cycle while the receiver does not stall, with the
// 24-stage quotient pipeline, the registered table read and all other stages
// advancing together.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_stall rises in the same cycle; it drops as soon as the result is taken.
// Reset clears all valid flags and loads origin 0, spacing 1.0, count 4.
// The coefficient table is not cleared; evaluating unloaded entries is undefined.
module cubic_bspline_evaluator import cbse_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [7:0]          i_coeff_index,
    input  logic signed [31:0]  i_coeff_value,
    input  logic signed [31:0]  i_sample_x,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [38:0]  o_spline_value,
    output logic                o_status
);

    logic signed [31:0] r_node_origin;
    logic [30:0]        r_node_spacing;
    logic [8:0]         r_coeff_count;

    logic en;

    logic               r_s0_valid;
    t_tag               r_s0_tag;
    logic signed [31:0] r_s0_x;

    logic               r_s1_valid;
    t_tag               r_s1_tag;
    logic signed [32:0] r_s1_d;

    logic                 div_valid;
    t_tag                 div_tag;
    logic [DIV_STEPS-1:0] div_q;

    logic [8:0]          cnt_eff;
    logic [COEFF_AW-1:0] ival;
    logic                range_bad;
    t_tag                n_p1_tag;

    logic                r_p1_valid;
    t_tag                r_p1_tag;
    logic [COEFF_AW-1:0] r_p1_base;
    logic [15:0]         r_p1_f;

    t_bank_data  mem_rdata;
    t_weight_set wgt;

    logic                  r_p2_valid, r_p3_valid, r_p4_valid, r_p5_valid, r_p6_valid;
    t_tag                  r_p2_tag, r_p3_tag, r_p4_tag, r_p5_tag, r_p6_tag;
    logic [BANK_SEL_W-1:0] r_p2_rot, r_p3_rot, r_p4_rot;
    t_bank_data            r_p3_data, r_p4_data;

    logic signed [63:0] n_p5_prod [BANKS];
    logic signed [63:0] r_p5_prod [BANKS];
    logic signed [63:0] r_p6_sum  [2];
    logic signed [63:0] acc;
    logic signed [63:0] acc_q16;

    logic               r_out_valid;
    logic signed [38:0] r_out_value;
    logic               r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_origin  <= 32'sd0;
            r_node_spacing <= 31'd65536;
            r_coeff_count  <= 9'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_ORIGIN:  r_node_origin  <= i_cfg_wdata;
                CFG_NODE_SPACING: r_node_spacing <= i_cfg_wdata[30:0];
                CFG_COEFF_COUNT:  r_coeff_count  <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_p4_valid  <= 1'b0;
            r_p5_valid  <= 1'b0;
            r_p6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid  <= i_in_valid;
            r_s1_valid  <= r_s0_valid;
            r_p1_valid  <= div_valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_p4_valid  <= r_p3_valid;
            r_p5_valid  <= r_p4_valid;
            r_p6_valid  <= r_p5_valid;
            r_out_valid <= r_p6_valid;
        end
    end

    cbse_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_s1_valid),
        .i_tag     (r_s1_tag),
        .i_d       (r_s1_d),
        .i_spacing (r_node_spacing),
        .o_valid   (div_valid),
        .o_tag     (div_tag),
        .o_q       (div_q)
    );

    assign cnt_eff   = (r_coeff_count > 9'(NUM_COEFFS)) ? 9'(NUM_COEFFS) : r_coeff_count;
    assign ival      = div_q[DIV_STEPS-1:16];
    assign range_bad = (ival == '0) || (({1'b0, ival} + 9'd2) >= cnt_eff);

    always_comb begin
        n_p1_tag     = div_tag;
        n_p1_tag.err = div_tag.err || ((div_tag.op == OP_EVAL) && range_bad);
    end

    cbse_coeff_mem u_mem (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r_p1_valid && (r_p1_tag.op == OP_LOAD)),
        .i_waddr (r_p1_tag.idx),
        .i_wdata (r_p1_tag.cval),
        .i_base  (r_p1_base),
        .o_rdata (mem_rdata)
    );

    cbse_weights u_wgt (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_f      (r_p1_f),
        .o_weight (wgt)
    );

    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            n_p5_prod[b] = 64'($signed(r_p4_data[b]))
                         * 64'($signed({1'b0, wgt[BANK_SEL_W'(b) - r_p4_rot]}));
        end
    end

    assign acc     = r_p6_sum[0] + r_p6_sum[1] + (64'sd1 <<< 27);
    assign acc_q16 = acc >>> 28;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_tag  <= '{op: i_operation, idx: i_coeff_index, cval: i_coeff_value,
                           err: 1'b0};
            r_s0_x    <= i_sample_x;
            r_s1_tag  <= r_s0_tag;
            r_s1_d    <= {r_s0_x[31], r_s0_x} - {r_node_origin[31], r_node_origin};
            r_p1_tag  <= n_p1_tag;
            r_p1_base <= ival - COEFF_AW'(1);
            r_p1_f    <= div_q[15:0];
            r_p2_tag  <= r_p1_tag;
            r_p2_rot  <= r_p1_base[BANK_SEL_W-1:0];
            r_p3_tag  <= r_p2_tag;
            r_p3_rot  <= r_p2_rot;
            r_p3_data <= mem_rdata;
            r_p4_tag  <= r_p3_tag;
            r_p4_rot  <= r_p3_rot;
            r_p4_data <= r_p3_data;
            r_p5_tag  <= r_p4_tag;
            for (int b = 0; b < BANKS; b++) begin
                r_p5_prod[b] <= n_p5_prod[b];
            end
            r_p6_tag    <= r_p5_tag;
            r_p6_sum[0] <= r_p5_prod[0] + r_p5_prod[1];
            r_p6_sum[1] <= r_p5_prod[2] + r_p5_prod[3];
            r_out_status <= r_p6_tag.err;
            if ((r_p6_tag.op == OP_EVAL) && !r_p6_tag.err) begin
                r_out_value <= acc_q16[38:0];
            end else begin
                r_out_value <= 39'sd0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_spline_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

// ===== rtl/cbse_checker.sv =====
`include "cubic_bspline_evaluator_defines.svh"

module cbse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [38:0] o_spline_value,
    input logic               o_status
);

    `CBSE_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall,
                     o_out_valid && $stable(o_spline_value) && $stable(o_status))
    `CBSE_ASSERT_IMP(a_err_zero, o_out_valid && o_status, o_spline_value == 39'sd0)
    `CBSE_ASSERT_IMP(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)
    `CBSE_ASSERT_RST(a_rst_clear, !o_out_valid)

endmodule

bind cubic_bspline_evaluator cbse_checker u_cbse_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cbse_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         NO_PROGRESS_LIMIT = 5000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         SQUEEZE_CYCLES = 300;
    localparam int         NUM_PHASES = 8;

    typedef struct {
        logic signed [38:0] value;
        logic               status;
    } t_spline_res;

    typedef struct {
        logic               op;
        logic [7:0]         idx;
        logic [31:0]        val;
        logic [31:0]        x;
        bit                 typed;
        logic signed [38:0] exp_value;
        logic               exp_status;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_operation = OP_LOAD;
    logic [7:0]         i_coeff_index = '0;
    logic signed [31:0] i_coeff_value = '0;
    logic signed [31:0] i_sample_x = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [38:0] o_spline_value;
    logic               o_status;

    cubic_bspline_evaluator u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // tb copy of block state
    longint      origin_q = 0;
    longint      spacing_q = 65536;
    int          count_q = 4;
    int          coeff_tbl [256];
    bit          coeff_loaded [256];

    t_spline_res pending_q [$];
    int          fails = 0;
    bit          idle_en = 1'b1;
    bit          squeeze_req = 1'b0;

    function automatic longint unsigned cube_weight(longint unsigned w);
        return (w * w * w + (64'd1 << 19)) >> 20;
    endfunction

    function automatic longint unsigned mid_weight(longint unsigned w);
        longint unsigned v;
        v = (64'd1 << 48) + 3 * (w << 32) + 3 * ((w * w) << 16) - 3 * (w * w * w);
        return (v + (64'd1 << 19)) >> 20;
    endfunction

    // returns 1 when an evaluate would touch an unloaded slot (first such slot in gap_slot)
    function automatic bit spline_predict(input logic op, input logic [7:0] idx,
                                          input logic [31:0] val, input logic [31:0] x,
                                          input bit commit, output t_spline_res res,
                                          output int gap_slot);
        longint xs, num, q, i, f, g, acc, cnt;
        xs = longint'($signed(x));
        res.value = '0;
        res.status = 1'b0;
        gap_slot = 0;
        if (op == OP_LOAD) begin
            if (commit) begin
                coeff_tbl[idx] = $signed(val);
                coeff_loaded[idx] = 1'b1;
            end
            return 1'b0;
        end
        if (spacing_q == 0) begin
            res.status = 1'b1;
            return 1'b0;
        end
        num = (xs - origin_q) * 65536;
        q = num / spacing_q;
        if (num % spacing_q != 0 && num < 0)
            q = q - 1;
        cnt = (count_q > NUM_COEFFS) ? longint'(NUM_COEFFS) : longint'(count_q);
        if (q < 65536) begin
            res.status = 1'b1;
            return 1'b0;
        end
        i = q >>> 16;
        f = q & 64'hFFFF;
        if (i + 2 >= cnt) begin
            res.status = 1'b1;
            return 1'b0;
        end
        for (int k = -1; k <= 2; k++) begin
            if (!coeff_loaded[i + k]) begin
                gap_slot = int'(i + k);
                return 1'b1;
            end
        end
        g = 65536 - f;
        acc = longint'(coeff_tbl[i - 1]) * longint'(cube_weight(g))
            + longint'(coeff_tbl[i]) * longint'(mid_weight(g))
            + longint'(coeff_tbl[i + 1]) * longint'(mid_weight(f))
            + longint'(coeff_tbl[i + 2]) * longint'(cube_weight(f));
        acc = (acc + (64'sd1 <<< 27)) >>> 28;
        res.value = acc[38:0];
        return 1'b0;
    endfunction

    task automatic cfg_write(input logic [1:0] index, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_NODE_ORIGIN)
            origin_q = longint'($signed(data));
        else if (index == CFG_NODE_SPACING)
            spacing_q = longint'(data[30:0]);
        else if (index == CFG_COEFF_COUNT)
            count_q = int'(data[8:0]);
    endtask

    task automatic send_request(input logic op, input logic [7:0] idx, input logic [31:0] val,
                                input logic [31:0] x);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_coeff_index <= idx;
        i_coeff_value <= val;
        i_sample_x <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // result side: check, then pick stall for next cycle
    int rx_hold = 0;
    int rx_burst = 0;
    bit squeeze_done = 1'b0;
    t_spline_res rx_exp;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_q.size() == 0) begin
                    $error("result with no request pending");
                    fails++;
                end else begin
                    rx_exp = pending_q.pop_front();
                    if (o_spline_value !== rx_exp.value) begin
                        $error("spline_value: expected %0d, got %0d", rx_exp.value,
                               o_spline_value);
                        fails++;
                    end
                    if (o_status !== rx_exp.status) begin
                        $error("status: expected %0d, got %0d", rx_exp.status, o_status);
                        fails++;
                    end
                end
            end
            if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                rx_hold = SQUEEZE_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else begin
                if (idle_en && rx_burst == 0 && $urandom_range(0, 5) == 0)
                    rx_burst = $urandom_range(1, 3);
                if (rx_burst > 0) begin
                    rx_burst--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= NO_PROGRESS_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row    dir_tab [17];
        longint      ph_origin [NUM_PHASES];
        longint      ph_spacing [NUM_PHASES];
        int          ph_count [NUM_PHASES];
        int          ph_items [NUM_PHASES];
        t_spline_res res;
        int          slot, pick, hi, ii;
        longint      xl, t;
        logic        op;
        logic [7:0]  idx;
        logic [31:0] val, x;

        // reset config: origin 0, spacing 1.0, count 4 -> only interval 1 valid
        dir_tab = '{
            '{OP_LOAD, 8'd0, 32'h7FFF_FFFF, 32'h0, 1, 39'sd0, 1'b0},
            '{OP_LOAD, 8'd1, 32'h8000_0000, 32'h0, 1, 39'sd0, 1'b0},
            '{OP_LOAD, 8'd2, 32'h7FFF_FFFF, 32'h0, 1, 39'sd0, 1'b0},
            '{OP_LOAD, 8'd3, 32'h8000_0000, 32'h0, 1, 39'sd0, 1'b0},
            '{OP_EVAL, 8'd0, 32'h0, 32'h0001_0000, 1, -39'sd4294967298, 1'b0},
            '{OP_EVAL, 8'd0, 32'h0, 32'h0, 1, 39'sd0, 1'b1},
            '{OP_EVAL, 8'd0, 32'h0, 32'h8000_0000, 1, 39'sd0, 1'b1},
            '{OP_EVAL, 8'd0, 32'h0, 32'h7FFF_FFFF, 1, 39'sd0, 1'b1},
            '{OP_EVAL, 8'd0, 32'h0, 32'h0002_0000, 1, 39'sd0, 1'b1},
            '{OP_EVAL, 8'd0, 32'h0, 32'h0001_8000, 0, 39'sd0, 1'b0},
            '{OP_EVAL, 8'd0, 32'h0, 32'h0001_FFFF, 0, 39'sd0, 1'b0},
            '{OP_EVAL, 8'd0, 32'h0, 32'h0001_0001, 0, 39'sd0, 1'b0},
            '{OP_LOAD, 8'd255, 32'hFFFF_FFFF, 32'h0, 1, 39'sd0, 1'b0},
            '{OP_LOAD, 8'd1, 32'h0000_0001, 32'h0, 1, 39'sd0, 1'b0},
            '{OP_EVAL, 8'd0, 32'h0, 32'h0001_8000, 0, 39'sd0, 1'b0},
            '{OP_LOAD, 8'd170, 32'h5555_5555, 32'h0, 1, 39'sd0, 1'b0},
            '{OP_LOAD, 8'd85, 32'hAAAA_AAAA, 32'h0, 1, 39'sd0, 1'b0}
        };

        ph_origin  = '{0, -2147483648, 2147483647, -2621440, 0, 0, 0, -196608};
        ph_spacing = '{65536, 2147483647, 1, 1, 0, 0, 65536, 32768};
        ph_count   = '{256, 256, 511, 256, 17, 256, 0, 200};
        ph_items   = '{200, 100, 50, 80, 120, 40, 30, 170};
        ph_origin[4]  = longint'($urandom_range(0, 2097152)) - 1048576;
        ph_spacing[4] = longint'($urandom_range(1, 1048576));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            void'(spline_predict(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].val, dir_tab[r].x,
                                 1'b1, res, slot));
            if (dir_tab[r].typed) begin
                res.value = dir_tab[r].exp_value;
                res.status = dir_tab[r].exp_status;
            end
            pending_q.push_back(res);
            send_request(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].val, dir_tab[r].x);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            i_in_valid <= 1'b0;
            drain();
            cfg_write(CFG_NODE_ORIGIN, ph_origin[p][31:0]);
            cfg_write(CFG_NODE_SPACING, ph_spacing[p][31:0]);
            cfg_write(CFG_COEFF_COUNT, ph_count[p][31:0]);
            if (p == 1)
                cfg_write(CFG_UNUSED, $urandom);
            idle_en = (p != NUM_PHASES - 1) && (p != 3);
            squeeze_req = (p == 0);
            for (int n = 0; n < ph_items[p]; n++) begin
                pick = $urandom_range(0, 9);
                op = (pick < 3) ? OP_LOAD : OP_EVAL;
                idx = 8'($urandom);
                val = rand_coeff();
                x = $urandom;
                hi = (count_q > NUM_COEFFS) ? NUM_COEFFS : count_q;
                if (pick >= 4 && hi >= 4) begin
                    ii = $urandom_range(1, hi - 3);
                    t = (longint'(ii) << 16) + longint'($urandom_range(0, 65535));
                    xl = origin_q + ((t * spacing_q) >>> 16);
                    if (xl >= -2147483648 && xl <= 2147483647)
                        x = xl[31:0];
                end
                if (spline_predict(op, idx, val, x, 1'b0, res, slot)) begin
                    op = OP_LOAD;
                    idx = slot[7:0];
                end
                void'(spline_predict(op, idx, val, x, 1'b1, res, slot));
                pending_q.push_back(res);
                send_request(op, idx, val, x);
            end
        end
        i_in_valid <= 1'b0;
        drain();
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== cubic_bspline_evaluator.f =====
+incdir+rtl
rtl/cbse_pkg.sv
rtl/cbse_div.sv
rtl/cbse_weights.sv
rtl/cbse_coeff_mem.sv
rtl/cubic_bspline_evaluator.sv
rtl/cbse_checker.sv
bench/tb_top.sv
